// ----- sv/tsv_pkg.sv -----
// Shared types, constants and the ring angle function for the tube sweep vertex generator.
// Used by tsv_norm, tube_sweep_vertex_generator and tsv_checker; depends on nothing.
package tsv_pkg;

	localparam logic [63:0] PI4_Q30 = 64'd843314857;
	localparam logic signed [15:0] ONE_Q14 = 16'sd16384;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIR_W,
		ST_RX,
		ST_RX_W,
		ST_UX,
		ST_UX_W,
		ST_NX,
		ST_NX_W,
		ST_VX,
		ST_EMIT
	} top_state_t;

	typedef enum logic [2:0] {
		NS_IDLE,
		NS_SCALE,
		NS_SUM,
		NS_SQRT,
		NS_DIV,
		NS_DONE
	} norm_state_t;

	function automatic logic [63:0] mul_q30(input logic [63:0] a, input logic [63:0] b);
		logic [63:0] p;
		p = a * b + 64'd536870912;
		return p >> 30;
	endfunction

	// sin and cos of an octant angle in Q30, returned as {sin, cos} in Q2.14
	function automatic logic [31:0] sincos_oct(input logic [63:0] x);
		logic [63:0] x2, x3, x4, x5, x6, x7, x8, su, cu;
		longint sv, cv;
		x2 = mul_q30(x, x);
		x3 = mul_q30(x2, x);
		x4 = mul_q30(x2, x2);
		x5 = mul_q30(x4, x);
		x6 = mul_q30(x4, x2);
		x7 = mul_q30(x6, x);
		x8 = mul_q30(x4, x4);
		sv = longint'(x) - longint'(x3 / 64'd6) + longint'(x5 / 64'd120)
			- longint'(x7 / 64'd5040);
		cv = longint'(64'd1073741824) - longint'(x2 / 64'd2) + longint'(x4 / 64'd24)
			- longint'(x6 / 64'd720) + longint'(x8 / 64'd40320);
		if (sv < 0) sv = 0;
		if (cv < 0) cv = 0;
		su = (64'(sv) + 64'd32768) >> 16;
		cu = (64'(cv) + 64'd32768) >> 16;
		return {su[15:0], cu[15:0]};
	endfunction

endpackage

// ----- sv/tsv_norm.sv -----
// Iterative vector normalizer: scale, sum of squares, integer square root, long division.
// Depends on tsv_pkg.
module tsv_norm (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [33:0] vec [3],
	output logic               done,
	output logic signed [15:0] res [3]
);

	tsv_pkg::norm_state_t state_q, state_d;

	logic [33:0] mag_q [3];
	logic        sgn_q [3];
	logic [63:0] sum_q, x_q, r_q, bit_q;
	logic [4:0]  it_q;
	logic [1:0]  k_q;
	logic [31:0] rem_q;
	logic [15:0] lo_q, q_q;
	logic [33:0] m;
	logic [61:0] sq;
	logic [45:0] num;
	logic [32:0] trial;
	logic        fit;
	logic [15:0] qn, qcap;

	always_comb begin
		m = mag_q[0];
		if (mag_q[1] > m) m = mag_q[1];
		if (mag_q[2] > m) m = mag_q[2];
		sq = mag_q[k_q][30:0] * mag_q[k_q][30:0];
		num = {1'b0, mag_q[k_q][30:0], 14'd0} + {14'd0, r_q[32:1]};
		trial = {rem_q, lo_q[15]};
		fit = trial >= {1'b0, r_q[31:0]};
		qn = {q_q[14:0], fit};
		qcap = (qn > 16'd16384) ? 16'd16384 : qn;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tsv_pkg::NS_IDLE:  if (start) state_d = tsv_pkg::NS_SCALE;
			tsv_pkg::NS_SCALE: begin
				if (m == '0) state_d = tsv_pkg::NS_DONE;
				else if (m[33:31] == '0 && m[30]) state_d = tsv_pkg::NS_SUM;
			end
			tsv_pkg::NS_SUM:   if (k_q == 2'd2) state_d = tsv_pkg::NS_SQRT;
			tsv_pkg::NS_SQRT:  if (it_q == 5'd31) state_d = tsv_pkg::NS_DIV;
			tsv_pkg::NS_DIV:   if (k_q == 2'd2 && it_q == 5'd16) state_d = tsv_pkg::NS_DONE;
			tsv_pkg::NS_DONE:  state_d = tsv_pkg::NS_IDLE;
			default:           state_d = tsv_pkg::NS_IDLE;
		endcase
	end

	always_comb begin
		done = state_q == tsv_pkg::NS_DONE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tsv_pkg::NS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			tsv_pkg::NS_IDLE: begin
				for (int i = 0; i < 3; i++) begin
					sgn_q[i] <= vec[i][33];
					mag_q[i] <= vec[i][33] ? 34'(-vec[i]) : 34'(vec[i]);
				end
				k_q <= '0;
				sum_q <= '0;
			end
			tsv_pkg::NS_SCALE: begin
				if (m == '0) begin
					for (int i = 0; i < 3; i++) res[i] <= '0;
				end else if (m[33:31] != '0) begin
					for (int i = 0; i < 3; i++) mag_q[i] <= mag_q[i] >> 1;
				end else if (!m[30]) begin
					for (int i = 0; i < 3; i++) mag_q[i] <= mag_q[i] << 1;
				end
			end
			tsv_pkg::NS_SUM: begin
				sum_q <= sum_q + {2'd0, sq};
				k_q <= (k_q == 2'd2) ? 2'd0 : k_q + 2'd1;
				if (k_q == 2'd2) begin
					x_q <= sum_q + {2'd0, sq};
					r_q <= '0;
					bit_q <= 64'd1 << 62;
					it_q <= '0;
				end
			end
			tsv_pkg::NS_SQRT: begin
				if (x_q >= r_q + bit_q) begin
					x_q <= x_q - (r_q + bit_q);
					r_q <= (r_q >> 1) + bit_q;
				end else begin
					r_q <= r_q >> 1;
				end
				bit_q <= bit_q >> 2;
				it_q <= (it_q == 5'd31) ? 5'd0 : it_q + 5'd1;
			end
			tsv_pkg::NS_DIV: begin
				if (it_q == 5'd0) begin
					rem_q <= {2'd0, num[45:16]};
					lo_q <= num[15:0];
					q_q <= '0;
					it_q <= 5'd1;
				end else begin
					rem_q <= fit ? 32'(trial - {1'b0, r_q[31:0]}) : trial[31:0];
					lo_q <= {lo_q[14:0], 1'b0};
					q_q <= qn;
					if (it_q == 5'd16) begin
						res[k_q] <= sgn_q[k_q] ? 16'(-$signed(qcap)) : $signed(qcap);
						it_q <= '0;
						k_q <= k_q + 2'd1;
					end else begin
						it_q <= it_q + 5'd1;
					end
				end
			end
			tsv_pkg::NS_DONE: begin
				k_q <= '0;
			end
			default: begin
				k_q <= '0;
			end
		endcase
	end

endmodule

// ----- sv/tube_sweep_vertex_generator.sv -----
// Top level of the tube sweep vertex generator: sequencer, frame math and output register.
// Depends on tsv_pkg and tsv_norm.
// Each route point after the first yields a ring of SIDES vertices around the previous point,
// and a closing point (route_end) adds its own ring. All vector normalizations run one at a time
// on the single iterative normalizer (start, scaling shifts, three squares, 32 square root
// steps, three long divisions, done). A point thus takes (SIDES + 3) normalizations, and a
// closing point adds (SIDES + 2) more for its own ring; a point that only starts a route
// is just stored. Output stalls hold each vertex in the emit state. Input stall is high while
// a point is in work.
module tube_sweep_vertex_generator #(
	parameter int SIDES = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [23:0]        cfg_wdata,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] point_x,
	input  logic signed [31:0] point_y,
	input  logic signed [31:0] point_z,
	input  logic               route_end,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] vertex_x,
	output logic signed [31:0] vertex_y,
	output logic signed [31:0] vertex_z,
	output logic signed [15:0] normal_x,
	output logic signed [15:0] normal_y,
	output logic signed [15:0] normal_z,
	output logic               last_of_run
);

	localparam int SW = (SIDES > 1) ? $clog2(SIDES) : 1;

	logic signed [15:0] cos_tab [SIDES];
	logic signed [15:0] sin_tab [SIDES];

	for (genvar j = 0; j < SIDES; j++) begin : g_ang
		localparam int T = j * 8;
		localparam int K = T / SIDES;
		localparam int REM = T % SIDES;
		localparam int NUM = (K % 2 == 1) ? SIDES - REM : REM;
		localparam int O = K % 8;
		localparam logic [63:0] X = (64'(NUM) * tsv_pkg::PI4_Q30 + 64'(SIDES / 2))
			/ 64'(SIDES);
		localparam logic [31:0] SC = tsv_pkg::sincos_oct(X);
		localparam logic signed [15:0] S0 = SC[31:16];
		localparam logic signed [15:0] C0 = SC[15:0];
		localparam logic signed [15:0] CV = (O == 0 || O == 7) ? C0 :
			(O == 1 || O == 6) ? S0 : (O == 2 || O == 5) ? -S0 : -C0;
		localparam logic signed [15:0] SV = (O == 0 || O == 3) ? S0 :
			(O == 1 || O == 2) ? C0 : (O == 4 || O == 7) ? -S0 : -C0;
		assign cos_tab[j] = CV;
		assign sin_tab[j] = SV;
	end

	tsv_pkg::top_state_t state_q, state_d;

	logic [23:0]        radius_q;
	logic               have_prev_q, end_q, second_q, go_q;
	logic [1:0]         comp_q;
	logic [SW-1:0]      side_q;
	logic signed [31:0] prev_q [3];
	logic signed [31:0] cur_q [3];
	logic signed [31:0] pt_q [3];
	logic signed [31:0] vtx_q [3];
	logic signed [33:0] tmp_q [3];
	logic signed [15:0] dir_q [3];
	logic signed [15:0] right_q [3];
	logic signed [15:0] up_q [3];
	logic signed [15:0] nrm_q [3];
	logic signed [31:0] cin [3];

	logic               nrm_done;
	logic signed [15:0] nres [3];

	logic signed [15:0] ca [3];
	logic signed [15:0] cb [3];
	logic [1:0]         i1, i2;
	logic signed [15:0] ma1, mb1, ma2, mb2;
	logic signed [31:0] p1, p2;
	logic signed [32:0] mix;
	logic signed [40:0] prod;
	logic signed [40:0] rnd;
	logic signed [33:0] vsum;
	logic signed [31:0] vsat;
	logic               side_last;

	assign cin[0] = point_x;
	assign cin[1] = point_y;
	assign cin[2] = point_z;

	tsv_norm u_norm (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (go_q),
		.vec    (tmp_q),
		.done   (nrm_done),
		.res    (nres)
	);

	always_comb begin
		unique case (comp_q)
			2'd0:    begin i1 = 2'd1; i2 = 2'd2; end
			2'd1:    begin i1 = 2'd2; i2 = 2'd0; end
			default: begin i1 = 2'd0; i2 = 2'd1; end
		endcase
		ca = dir_q;
		cb = up_q;
		if (state_q == tsv_pkg::ST_UX) begin
			ca = right_q;
			cb = dir_q;
		end
		if (state_q == tsv_pkg::ST_NX) begin
			ma1 = right_q[comp_q];
			mb1 = cos_tab[side_q];
			ma2 = up_q[comp_q];
			mb2 = sin_tab[side_q];
		end else begin
			ma1 = ca[i1];
			mb1 = cb[i2];
			ma2 = ca[i2];
			mb2 = cb[i1];
		end
		p1 = ma1 * mb1;
		p2 = ma2 * mb2;
		mix = (state_q == tsv_pkg::ST_NX) ? 33'(p1) + 33'(p2) : 33'(p1) - 33'(p2);
		prod = 41'(nrm_q[comp_q]) * $signed({17'd0, radius_q});
		rnd = (prod + 41'sd8192) >>> 14;
		vsum = 34'(pt_q[comp_q]) + 34'($signed(rnd[26:0]));
		if (vsum[33:31] == 3'b000 || vsum[33:31] == 3'b111) vsat = vsum[31:0];
		else vsat = vsum[33] ? 32'sh8000_0000 : 32'sh7fff_ffff;
		side_last = side_q == SW'(SIDES - 1);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tsv_pkg::ST_IDLE:  if (in_valid && have_prev_q) state_d = tsv_pkg::ST_DIR_W;
			tsv_pkg::ST_DIR_W: if (nrm_done) state_d = tsv_pkg::ST_RX;
			tsv_pkg::ST_RX:    if (comp_q == 2'd2) state_d = tsv_pkg::ST_RX_W;
			tsv_pkg::ST_RX_W:  if (nrm_done) state_d = tsv_pkg::ST_UX;
			tsv_pkg::ST_UX:    if (comp_q == 2'd2) state_d = tsv_pkg::ST_UX_W;
			tsv_pkg::ST_UX_W:  if (nrm_done) state_d = tsv_pkg::ST_NX;
			tsv_pkg::ST_NX:    if (comp_q == 2'd2) state_d = tsv_pkg::ST_NX_W;
			tsv_pkg::ST_NX_W:  if (nrm_done) state_d = tsv_pkg::ST_VX;
			tsv_pkg::ST_VX:    if (comp_q == 2'd2) state_d = tsv_pkg::ST_EMIT;
			tsv_pkg::ST_EMIT: begin
				if (!out_stall) begin
					if (!side_last) state_d = tsv_pkg::ST_NX;
					else if (end_q && !second_q) state_d = tsv_pkg::ST_RX;
					else state_d = tsv_pkg::ST_IDLE;
				end
			end
			default:           state_d = tsv_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall = state_q != tsv_pkg::ST_IDLE;
		out_valid = state_q == tsv_pkg::ST_EMIT;
		last_of_run = side_last && (second_q || !end_q);
		vertex_x = vtx_q[0];
		vertex_y = vtx_q[1];
		vertex_z = vtx_q[2];
		normal_x = nrm_q[0];
		normal_y = nrm_q[1];
		normal_z = nrm_q[2];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tsv_pkg::ST_IDLE;
			radius_q <= 24'd32768;
			have_prev_q <= 1'b0;
			end_q <= 1'b0;
			second_q <= 1'b0;
			go_q <= 1'b0;
			comp_q <= '0;
			side_q <= '0;
			for (int i = 0; i < 3; i++) begin
				prev_q[i] <= '0;
			end
			up_q[0] <= '0;
			up_q[1] <= tsv_pkg::ONE_Q14;
			up_q[2] <= '0;
		end else begin
			state_q <= state_d;
			go_q <= (state_q == tsv_pkg::ST_IDLE && in_valid && have_prev_q) ||
				((state_q == tsv_pkg::ST_RX || state_q == tsv_pkg::ST_UX ||
				state_q == tsv_pkg::ST_NX) && comp_q == 2'd2);
			if (cfg_we) radius_q <= cfg_wdata;
			unique case (state_q)
				tsv_pkg::ST_IDLE: begin
					comp_q <= '0;
					side_q <= '0;
					second_q <= 1'b0;
					if (in_valid) begin
						end_q <= route_end;
						have_prev_q <= !route_end;
						for (int i = 0; i < 3; i++) begin
							prev_q[i] <= cin[i];
							cur_q[i] <= cin[i];
							pt_q[i] <= prev_q[i];
							tmp_q[i] <= 34'(cin[i]) - 34'(prev_q[i]);
						end
					end
				end
				tsv_pkg::ST_DIR_W: if (nrm_done) dir_q <= nres;
				tsv_pkg::ST_RX_W:  if (nrm_done) right_q <= nres;
				tsv_pkg::ST_UX_W:  if (nrm_done) up_q <= nres;
				tsv_pkg::ST_NX_W:  if (nrm_done) nrm_q <= nres;
				tsv_pkg::ST_RX, tsv_pkg::ST_UX, tsv_pkg::ST_NX: begin
					tmp_q[comp_q] <= 34'(mix);
					comp_q <= (comp_q == 2'd2) ? 2'd0 : comp_q + 2'd1;
				end
				tsv_pkg::ST_VX: begin
					vtx_q[comp_q] <= vsat;
					comp_q <= (comp_q == 2'd2) ? 2'd0 : comp_q + 2'd1;
				end
				tsv_pkg::ST_EMIT: begin
					if (!out_stall) begin
						if (!side_last) begin
							side_q <= side_q + SW'(1);
						end else if (end_q && !second_q) begin
							second_q <= 1'b1;
							side_q <= '0;
							pt_q <= cur_q;
						end else if (end_q) begin
							up_q[0] <= '0;
							up_q[1] <= tsv_pkg::ONE_Q14;
							up_q[2] <= '0;
						end
					end
				end
				default: begin
					comp_q <= '0;
				end
			endcase
		end
	end

endmodule

// ----- verif/tsv_checker.sv -----
// Checker for the tube sweep vertex generator: watches the register port and both request
// channels, predicts every ring vertex and compares it with what the block sends.
// Depends on tsv_pkg for the fixed-point constants.
`timescale 1ns / 1ps
module tsv_checker #(
	parameter int SIDES = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [23:0]        cfg_wdata,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic signed [31:0] point_x,
	input  logic signed [31:0] point_y,
	input  logic signed [31:0] point_z,
	input  logic               route_end,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic signed [31:0] vertex_x,
	input  logic signed [31:0] vertex_y,
	input  logic signed [31:0] vertex_z,
	input  logic signed [15:0] normal_x,
	input  logic signed [15:0] normal_y,
	input  logic signed [15:0] normal_z,
	input  logic               last_of_run,
	output int                 fail_count,
	output int                 vertices_due
);

	typedef struct {
		logic signed [31:0] vx, vy, vz;
		logic signed [15:0] nx, ny, nz;
		logic               last;
	} vertex_t;

	vertex_t ring_q[$];
	int cos_lut[SIDES];
	int sin_lut[SIDES];
	logic [23:0] radius;
	longint held_x, held_y, held_z;
	bit held;
	int up_x, up_y, up_z;

	function automatic logic [63:0] q30_mul(input logic [63:0] a, input logic [63:0] b);
		return (a * b + 64'd536870912) >> 30;
	endfunction

	task automatic octant_trig(input logic [63:0] x, output int s, output int c);
		logic [63:0] x2, x3, x4, x5, x6, x7, x8;
		longint sv, cv;
		x2 = q30_mul(x, x);
		x3 = q30_mul(x2, x);
		x4 = q30_mul(x2, x2);
		x5 = q30_mul(x4, x);
		x6 = q30_mul(x4, x2);
		x7 = q30_mul(x6, x);
		x8 = q30_mul(x4, x4);
		sv = longint'(x) - longint'(x3 / 6) + longint'(x5 / 120) - longint'(x7 / 5040);
		cv = 64'sd1073741824 - longint'(x2 / 2) + longint'(x4 / 24) - longint'(x6 / 720)
			+ longint'(x8 / 40320);
		if (sv < 0) sv = 0;
		if (cv < 0) cv = 0;
		s = int'((sv + 32768) >>> 16);
		c = int'((cv + 32768) >>> 16);
	endtask

	function automatic logic [63:0] root(input logic [63:0] x);
		logic [63:0] res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > x) b = b >> 2;
		while (b != 0) begin
			if (x >= res + b) begin
				x = x - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	task automatic unit_vec(input longint a, input longint b, input longint c,
			output int o0, output int o1, output int o2);
		logic [63:0] m0, m1, m2, mx, r, n0, n1, n2;
		m0 = (a < 0) ? 64'(-a) : 64'(a);
		m1 = (b < 0) ? 64'(-b) : 64'(b);
		m2 = (c < 0) ? 64'(-c) : 64'(c);
		mx = m0;
		if (m1 > mx) mx = m1;
		if (m2 > mx) mx = m2;
		if (mx == 0) begin
			o0 = 0;
			o1 = 0;
			o2 = 0;
			return;
		end
		while (mx >= 64'd2147483648) begin
			m0 = m0 >> 1;
			m1 = m1 >> 1;
			m2 = m2 >> 1;
			mx = mx >> 1;
		end
		while (mx < 64'd1073741824) begin
			m0 = m0 << 1;
			m1 = m1 << 1;
			m2 = m2 << 1;
			mx = mx << 1;
		end
		r = root(m0 * m0 + m1 * m1 + m2 * m2);
		n0 = (m0 * 16384 + r / 2) / r;
		n1 = (m1 * 16384 + r / 2) / r;
		n2 = (m2 * 16384 + r / 2) / r;
		if (n0 > 16384) n0 = 16384;
		if (n1 > 16384) n1 = 16384;
		if (n2 > 16384) n2 = 16384;
		o0 = (a < 0) ? -int'(n0) : int'(n0);
		o1 = (b < 0) ? -int'(n1) : int'(n1);
		o2 = (c < 0) ? -int'(n2) : int'(n2);
	endtask

	function automatic logic signed [31:0] place(input longint p, input int n);
		longint s;
		s = p + ((longint'(n) * longint'({40'd0, radius}) + 8192) >>> 14);
		if (s > 64'sd2147483647) s = 64'sd2147483647;
		if (s < -64'sd2147483648) s = -64'sd2147483648;
		return s[31:0];
	endfunction

	task automatic push_ring(input longint px, input longint py, input longint pz,
			input int dx, input int dy, input int dz);
		int rx, ry, rz, ux, uy, uz, nx, ny, nz;
		vertex_t v;
		unit_vec(longint'(dy) * up_z - longint'(dz) * up_y,
			longint'(dz) * up_x - longint'(dx) * up_z,
			longint'(dx) * up_y - longint'(dy) * up_x, rx, ry, rz);
		unit_vec(longint'(ry) * dz - longint'(rz) * dy,
			longint'(rz) * dx - longint'(rx) * dz,
			longint'(rx) * dy - longint'(ry) * dx, ux, uy, uz);
		up_x = ux;
		up_y = uy;
		up_z = uz;
		for (int j = 0; j < SIDES; j++) begin
			unit_vec(longint'(rx) * cos_lut[j] + longint'(ux) * sin_lut[j],
				longint'(ry) * cos_lut[j] + longint'(uy) * sin_lut[j],
				longint'(rz) * cos_lut[j] + longint'(uz) * sin_lut[j], nx, ny, nz);
			v.vx = place(px, nx);
			v.vy = place(py, ny);
			v.vz = place(pz, nz);
			v.nx = nx[15:0];
			v.ny = ny[15:0];
			v.nz = nz[15:0];
			v.last = 1'b0;
			ring_q.push_back(v);
		end
	endtask

	initial begin
		int t, k, rem, num, s0, c0;
		logic [63:0] x;
		for (int j = 0; j < SIDES; j++) begin
			t = j * 8;
			k = t / SIDES;
			rem = t % SIDES;
			num = (k & 1) ? (SIDES - rem) : rem;
			x = (64'(num) * tsv_pkg::PI4_Q30 + SIDES / 2) / SIDES;
			octant_trig(x, s0, c0);
			case (k & 7)
				0: begin cos_lut[j] = c0;  sin_lut[j] = s0;  end
				1: begin cos_lut[j] = s0;  sin_lut[j] = c0;  end
				2: begin cos_lut[j] = -s0; sin_lut[j] = c0;  end
				3: begin cos_lut[j] = -c0; sin_lut[j] = s0;  end
				4: begin cos_lut[j] = -c0; sin_lut[j] = -s0; end
				5: begin cos_lut[j] = -s0; sin_lut[j] = -c0; end
				6: begin cos_lut[j] = s0;  sin_lut[j] = -c0; end
				default: begin cos_lut[j] = c0; sin_lut[j] = -s0; end
			endcase
		end
	end

	always @(posedge clk or negedge arst_n) begin
		int dx, dy, dz;
		vertex_t e;
		if (!arst_n) begin
			radius = 24'd32768;
			held_x = 0;
			held_y = 0;
			held_z = 0;
			held = 0;
			up_x = 0;
			up_y = int'(tsv_pkg::ONE_Q14);
			up_z = 0;
			fail_count = 0;
			ring_q.delete();
		end else begin
			if (cfg_we) radius = cfg_wdata;
			if (out_valid && !out_stall) begin
				if (ring_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("%0t: vertex with none pending: %0d %0d %0d", $realtime,
							vertex_x, vertex_y, vertex_z);
				end else begin
					e = ring_q.pop_front();
					if (vertex_x !== e.vx || vertex_y !== e.vy || vertex_z !== e.vz ||
							normal_x !== e.nx || normal_y !== e.ny || normal_z !== e.nz ||
							last_of_run !== e.last) begin
						fail_count++;
						if (fail_count <= 10) begin
							$display("%0t: got v=(%0d %0d %0d) n=(%0d %0d %0d) l=%0b",
								$realtime, vertex_x, vertex_y, vertex_z, normal_x,
								normal_y, normal_z, last_of_run);
							$display("    want v=(%0d %0d %0d) n=(%0d %0d %0d) l=%0b",
								e.vx, e.vy, e.vz, e.nx, e.ny, e.nz, e.last);
						end
					end
				end
			end
			if (in_valid && !in_stall) begin
				if (held) begin
					unit_vec(longint'(point_x) - held_x, longint'(point_y) - held_y,
						longint'(point_z) - held_z, dx, dy, dz);
					push_ring(held_x, held_y, held_z, dx, dy, dz);
					if (route_end)
						push_ring(longint'(point_x), longint'(point_y), longint'(point_z),
							dx, dy, dz);
					ring_q[ring_q.size() - 1].last = 1'b1;
				end
				held_x = point_x;
				held_y = point_y;
				held_z = point_z;
				if (route_end) begin
					held = 0;
					up_x = 0;
					up_y = int'(tsv_pkg::ONE_Q14);
					up_z = 0;
				end else begin
					held = 1;
				end
			end
		end
		vertices_due = ring_q.size();
	end
endmodule

// ----- verif/tb_tube_sweep_vertex_generator.sv -----
// Testbench top for the tube sweep vertex generator: clock, reset, route stimulus,
// radius settings and random stalls; depends on the block and on tsv_checker.
`timescale 1ns / 1ps
module tb_tube_sweep_vertex_generator;
	localparam int SIDES = 8;
	localparam int CYCLE_LIMIT = 12000000;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [23:0] cfg_wdata = 0;
	logic in_valid = 0;
	logic in_stall;
	logic signed [31:0] point_x = 0, point_y = 0, point_z = 0;
	logic route_end = 0;
	logic out_valid;
	logic out_stall = 0;
	logic signed [31:0] vertex_x, vertex_y, vertex_z;
	logic signed [15:0] normal_x, normal_y, normal_z;
	logic last_of_run;
	int fail_count, vertices_due;

	tube_sweep_vertex_generator #(.SIDES(SIDES)) i_dut (.*);
	tsv_checker #(.SIDES(SIDES)) i_checker (.*);

	initial forever #5 clk = ~clk;

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("Mismatches found");
		$finish;
	end

	// random output stall: short bursts, rare long holds, and calm stretches
	int stall_run = 0;
	always @(posedge clk) begin
		if (stall_run > 0) begin
			stall_run <= stall_run - 1;
		end else if (out_stall) begin
			out_stall <= 1'b0;
			stall_run <= ($urandom_range(0, 7) == 0) ? $urandom_range(100, 400)
				: $urandom_range(0, 10);
		end else begin
			out_stall <= 1'b1;
			stall_run <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
				: $urandom_range(0, 3);
		end
	end

	task automatic send_point(input logic [31:0] x, input logic [31:0] y,
			input logic [31:0] z, input logic e);
		int r;
		in_valid <= 1'b1;
		point_x <= x;
		point_y <= y;
		point_z <= z;
		route_end <= e;
		do @(posedge clk); while (in_stall);
		r = $urandom_range(0, 9);
		if (r >= 5) begin
			in_valid <= 1'b0;
			repeat ((r == 9) ? $urandom_range(20, 200) : $urandom_range(1, 3))
				@(posedge clk);
		end
	endtask

	task automatic set_radius(input logic [23:0] v);
		in_valid <= 1'b0;
		@(posedge clk);
		while (vertices_due != 0 || in_stall) @(posedge clk);
		repeat (20) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [31:0] pick_coord(input int kind);
		case (kind)
			0: return $urandom;
			1: return 32'(int'($urandom_range(0, 2097152)) - 1048576);
			2: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
			default: return 32'(int'($urandom_range(0, 524288)) - 262144);
		endcase
	endfunction

	task automatic random_routes(input int count);
		int len, kind, sent;
		logic [31:0] x, y, z;
		sent = 0;
		while (sent < count) begin
			len = $urandom_range(1, 6);
			x = pick_coord(1);
			y = pick_coord(1);
			z = pick_coord(1);
			for (int i = 0; i < len; i++) begin
				kind = $urandom_range(0, 19);
				if (kind < 10) begin
					x = x + pick_coord(3);
					y = y + pick_coord(3);
					z = z + pick_coord(3);
				end else if (kind < 13) begin
					x = pick_coord(0);
					y = pick_coord(0);
					z = pick_coord(0);
				end else if (kind == 13) begin
					x = pick_coord(2);
					y = pick_coord(2);
					z = pick_coord(2);
				end else if (kind == 14) begin
					y = y + pick_coord(3);
				end else if (kind > 16) begin
					x = x + pick_coord(1);
					y = y + pick_coord(1);
					z = z + pick_coord(1);
				end
				send_point(x, y, z, i == len - 1);
				sent++;
			end
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_point(0, 0, 0, 1'b0);
		send_point(32'h10000, 0, 0, 1'b0);
		send_point(32'h10000, 32'h10000, 0, 1'b1);
		send_point(32'h30000, 32'h30000, 32'h30000, 1'b1);
		send_point(5, 5, 5, 1'b0);
		send_point(5, 5, 5, 1'b0);
		send_point(5, 5, 5, 1'b1);
		send_point(0, 0, 0, 1'b0);
		send_point(0, 32'h10000, 0, 1'b0);
		send_point(0, 32'h20000, 0, 1'b1);
		send_point(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 1'b0);
		send_point(32'h80000000, 32'h80000000, 32'h80000000, 1'b1);
		send_point(32'h80000000, 32'h7FFFFFFF, 32'h80000000, 1'b0);
		send_point(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 1'b1);
		set_radius(24'd8388608);
		send_point(32'h7FFFF000, 32'h7FFFF000, 0, 1'b0);
		send_point(32'h80001000, 32'h7FFFF000, 32'h1000, 1'b1);
		set_radius(24'hFFFFFF);
		send_point(32'h7FFFFFF0, 0, 32'h80000010, 1'b0);
		send_point(32'h7FFFFFF0, 32'h10000, 32'h80000010, 1'b1);
		set_radius(24'd0);
		send_point(32'h1234, 32'h5678, 32'h9ABC, 1'b0);
		send_point(32'h11234, 32'h5678, 32'h19ABC, 1'b1);

		random_routes(95);
		set_radius(24'd8388608);
		random_routes(95);
		set_radius(24'd32768);
		random_routes(95);
		set_radius(24'($urandom_range(1, 8388607)));
		random_routes(95);
		set_radius(24'hFFFFFF);
		random_routes(80);

		in_valid <= 1'b0;
		@(posedge clk);
		while (vertices_due != 0) @(posedge clk);
		repeat (500) @(posedge clk);
		if (fail_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule

// ----- filelist.f -----
sv/tsv_pkg.sv
sv/tsv_norm.sv
sv/tube_sweep_vertex_generator.sv
verif/tsv_checker.sv
verif/tb_tube_sweep_vertex_generator.sv
